// File: rtl/rgbyp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbyp_pkg
// Shared types and constants of the RGB565 to YUYV 4:2:2 packer.
// ----------------------------------------------------------------------------
package rgbyp_pkg;

   localparam int PixelW       = 16;
   localparam int ByteW        = 8;
   localparam int ColW         = 10;
   localparam int RowW         = 9;
   localparam int AddrW        = 17;
   localparam int CsrIndexW    = 2;
   localparam int CsrDataW     = 10;
   localparam int MaxOutWidth  = 512;
   localparam int MaxOutHeight = 480;
   localparam int QueueDepth   = 4;
   localparam int QueuePtrW    = $clog2(QueueDepth);
   localparam int QueueCountW  = $clog2(QueueDepth + 1);

   localparam logic [ColW-1:0] RowPixelsReset = ColW'(256);
   localparam logic [RowW-1:0] FrameRowsReset = RowW'(240);

   typedef enum logic [CsrIndexW-1:0] {
      CSR_UPSCALE    = 2'd0,
      CSR_ROW_PIXELS = 2'd1,
      CSR_FRAME_ROWS = 2'd2
   } csr_index_type;

   // What the back end does with one pixel
   typedef enum logic [1:0] {
      KIND_HOLD   = 2'd0,   // even native pixel, kept for pairing
      KIND_SINGLE = 2'd1,   // last native pixel of an odd row, paired with itself
      KIND_PAIR   = 2'd2,   // odd native pixel, paired with held one
      KIND_DUP    = 2'd3    // upscale, two beats
   } kind_type;

   typedef struct packed {
      logic            upscale;
      logic [ColW-1:0] row_pixels;
      logic [RowW-1:0] frame_rows;
   } cfg_type;

   typedef struct packed {
      logic [PixelW-1:0] pixel;
      kind_type          kind;
      logic [AddrW-1:0]  addr_first;
      logic [AddrW-1:0]  addr_second;
      logic              frame_end;
   } job_type;

   typedef struct packed {
      logic             push;
      logic             pop;
      logic             full;
      logic             head_valid;
   } queue_ctl_type;

endpackage

// File: rtl/rgbyp_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbyp_req_if
// Pixel request channel: one RGB565 pixel per beat.
// ----------------------------------------------------------------------------
interface rgbyp_req_if;
   logic                        valid;
   logic                        ready;
   logic [rgbyp_pkg::PixelW-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

// File: rtl/rgbyp_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbyp_rsp_if
// Word response channel: one addressed YUYV word per beat.
// ----------------------------------------------------------------------------
interface rgbyp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rgbyp_pkg::ByteW-1:0] luma_first;
   logic [rgbyp_pkg::ByteW-1:0] chroma_blue;
   logic [rgbyp_pkg::ByteW-1:0] luma_second;
   logic [rgbyp_pkg::ByteW-1:0] chroma_red;
   logic [rgbyp_pkg::AddrW-1:0] word_address;
   logic                        frame_end;

   modport source (output valid, output luma_first, output chroma_blue,
                   output luma_second, output chroma_red, output word_address,
                   output frame_end, input ready);
   modport sink   (input valid, input luma_first, input chroma_blue,
                   input luma_second, input chroma_red, input word_address,
                   input frame_end, output ready);
endinterface

// File: rtl/rgbyp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbyp_front
// Accepts pixels, tracks column, row and row base, and classifies each pixel.
// ----------------------------------------------------------------------------
module rgbyp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  rgbyp_pkg::cfg_type      cfg,
   rgbyp_req_if.sink               req_ch,
   input  logic                    queue_full,
   output logic                    job_push,
   output rgbyp_pkg::job_type      job
);
   import rgbyp_pkg::*;

   localparam logic [ColW-1:0] WidthCap   = ColW'(MaxOutWidth);
   localparam logic [ColW-1:0] WidthCapUp = ColW'(MaxOutWidth / 2);
   localparam logic [RowW-1:0] RowsCap    = RowW'(MaxOutHeight);
   localparam logic [RowW-1:0] RowsCapUp  = RowW'(MaxOutHeight / 2);

   logic [ColW-1:0]  col_ff, col_in;
   logic [RowW-1:0]  row_ff, row_in;
   logic [AddrW-1:0] base_ff, base_in;

   logic [ColW-1:0]  width_cap, rp;
   logic [RowW-1:0]  rows_cap, fr;
   logic             row_last, frame_last, accept;
   logic [AddrW-1:0] stride, addr_native, addr_up;

   always_comb begin
      width_cap = cfg.upscale ? WidthCapUp : WidthCap;
      rows_cap  = cfg.upscale ? RowsCapUp : RowsCap;
      rp = (cfg.row_pixels == '0) ? ColW'(1) : cfg.row_pixels;
      if (rp > width_cap) begin
         rp = width_cap;
      end
      fr = (cfg.frame_rows == '0) ? RowW'(1) : cfg.frame_rows;
      if (fr > rows_cap) begin
         fr = rows_cap;
      end
   end

   assign row_last   = ({1'b0, col_ff} + (ColW+1)'(1)) >= {1'b0, rp};
   assign frame_last = row_last && (({1'b0, row_ff} + (RowW+1)'(1)) >= {1'b0, fr});

   assign addr_native = base_ff + AddrW'(col_ff >> 1);
   assign addr_up     = base_ff + AddrW'(col_ff);
   assign stride      = cfg.upscale ? AddrW'({rp, 1'b0})
                                    : AddrW'(({1'b0, rp} + (ColW+1)'(1)) >> 1);

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && !queue_full;
   assign job_push     = accept;

   always_comb begin
      job.pixel       = req_ch.pixel;
      job.frame_end   = frame_last;
      job.addr_second = addr_up + AddrW'(rp);
      if (cfg.upscale) begin
         job.kind       = KIND_DUP;
         job.addr_first = addr_up;
      end else begin
         job.addr_first = addr_native;
         if (col_ff[0]) begin
            job.kind = KIND_PAIR;
         end else if (row_last) begin
            job.kind = KIND_SINGLE;
         end else begin
            job.kind = KIND_HOLD;
         end
      end
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      base_in = base_ff;
      if (accept) begin
         if (row_last) begin
            col_in = '0;
            if (frame_last) begin
               row_in  = '0;
               base_in = '0;
            end else begin
               row_in  = row_ff + RowW'(1);
               base_in = base_ff + stride;
            end
         end else begin
            col_in = col_ff + ColW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         base_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         base_ff <= base_in;
      end
   end

endmodule

// File: rtl/rgbyp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbyp_queue
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module rgbyp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rgbyp_pkg::job_type   push_job,
   input  logic                 pop,
   output logic                 full,
   output logic                 head_valid,
   output rgbyp_pkg::job_type   head_job
);
   import rgbyp_pkg::*;

   localparam logic [QueuePtrW-1:0]   LastPtr = QueuePtrW'(QueueDepth - 1);
   localparam logic [QueueCountW-1:0] Depth   = QueueCountW'(QueueDepth);

   job_type                mem_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QueueCountW-1:0] count_ff, count_in;

   assign full       = count_ff == Depth;
   assign head_valid = count_ff != '0;
   assign head_job   = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == LastPtr) ? '0 : wr_ff + QueuePtrW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == LastPtr) ? '0 : rd_ff + QueuePtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QueueCountW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QueueCountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/rgbyp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbyp_back
// Converts queued pixels to YCbCr, pairs or duplicates them, drives words.
// ----------------------------------------------------------------------------
module rgbyp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  rgbyp_pkg::job_type   head_job,
   output logic                 pop,
   rgbyp_rsp_if.source          rsp_ch
);
   import rgbyp_pkg::*;

   localparam int SumW = 18;

   // conversion, from the queue head
   logic [ByteW-1:0]       r8, g8, b8;
   logic signed [SumW-1:0] rs, gs, bs, y_sum, cb_sum, cr_sum;
   logic signed [SumW-1:0] y_sh, cb_sh, cr_sh;

   // stage 1
   logic             s1_valid_ff, s1_valid_in;
   logic [ByteW-1:0] s1_y_ff, s1_cb_ff, s1_cr_ff;
   job_type          s1_job_ff;
   logic             phase_ff, phase_in;

   logic [ByteW-1:0] held_y_ff, held_y_in, held_cb_ff, held_cb_in, held_cr_ff, held_cr_in;

   // output register
   logic             out_valid_ff, out_valid_in;
   logic [ByteW-1:0] out_y0_ff, out_cb_ff, out_y1_ff, out_cr_ff;
   logic [AddrW-1:0] out_addr_ff;
   logic             out_end_ff;

   logic             out_free, emit, s1_done, is_dup, is_pair, is_hold;
   logic [ByteW:0]   cb_avg_sum, cr_avg_sum;

   always_comb begin
      r8 = {head_job.pixel[15:11], head_job.pixel[15:13]};
      g8 = {head_job.pixel[10:5], head_job.pixel[10:9]};
      b8 = {head_job.pixel[4:0], head_job.pixel[4:2]};
      rs = $signed({10'd0, r8});
      gs = $signed({10'd0, g8});
      bs = $signed({10'd0, b8});
      y_sum  = 18'sd66 * rs + 18'sd129 * gs + 18'sd25 * bs;
      cb_sum = 18'sd112 * bs - 18'sd38 * rs - 18'sd74 * gs;
      cr_sum = 18'sd112 * rs - 18'sd94 * gs - 18'sd18 * bs;
      y_sh   = y_sum >>> 8;
      cb_sh  = cb_sum >>> 8;
      cr_sh  = cr_sum >>> 8;
   end

   assign is_dup  = s1_job_ff.kind == KIND_DUP;
   assign is_pair = s1_job_ff.kind == KIND_PAIR;
   assign is_hold = s1_job_ff.kind == KIND_HOLD;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign emit     = s1_valid_ff && !is_hold && out_free;
   assign s1_done  = s1_valid_ff && (is_hold || (out_free && (!is_dup || phase_ff)));
   assign pop      = head_valid && (!s1_valid_ff || s1_done);

   assign cb_avg_sum = {1'b0, held_cb_ff} + {1'b0, s1_cb_ff};
   assign cr_avg_sum = {1'b0, held_cr_ff} + {1'b0, s1_cr_ff};

   always_comb begin
      s1_valid_in  = pop ? 1'b1 : (s1_done ? 1'b0 : s1_valid_ff);
      phase_in     = (emit && is_dup) ? !phase_ff : phase_ff;
      out_valid_in = emit ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
      held_y_in    = held_y_ff;
      held_cb_in   = held_cb_ff;
      held_cr_in   = held_cr_ff;
      if (s1_done && is_hold) begin
         held_y_in  = s1_y_ff;
         held_cb_in = s1_cb_ff;
         held_cr_in = s1_cr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_y_ff   <= y_sh[ByteW-1:0] + ByteW'(16);
         s1_cb_ff  <= cb_sh[ByteW-1:0] + ByteW'(128);
         s1_cr_ff  <= cr_sh[ByteW-1:0] + ByteW'(128);
         s1_job_ff <= head_job;
      end
      if (emit) begin
         out_y0_ff   <= is_pair ? held_y_ff : s1_y_ff;
         out_cb_ff   <= is_pair ? cb_avg_sum[ByteW:1] : s1_cb_ff;
         out_y1_ff   <= s1_y_ff;
         out_cr_ff   <= is_pair ? cr_avg_sum[ByteW:1] : s1_cr_ff;
         out_addr_ff <= (is_dup && phase_ff) ? s1_job_ff.addr_second : s1_job_ff.addr_first;
         out_end_ff  <= s1_job_ff.frame_end && (!is_dup || phase_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         held_y_ff    <= '0;
         held_cb_ff   <= '0;
         held_cr_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
         held_y_ff    <= held_y_in;
         held_cb_ff   <= held_cb_in;
         held_cr_ff   <= held_cr_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.luma_first   = out_y0_ff;
   assign rsp_ch.chroma_blue  = out_cb_ff;
   assign rsp_ch.luma_second  = out_y1_ff;
   assign rsp_ch.chroma_red   = out_cr_ff;
   assign rsp_ch.word_address = out_addr_ff;
   assign rsp_ch.frame_end    = out_end_ff;

endmodule

// File: rtl/rgb565_to_yuyv422_packer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_to_yuyv422_packer_top
// RGB565 to BT.601 YUYV 4:2:2 packer with frame buffer word addressing.
// ----------------------------------------------------------------------------
//  channel   dir   beat
//  req_ch    in    one RGB565 pixel, raster order
//  rsp_ch    out   one YUYV word with word address and frame end flag
//  csr_*     in    register write: index, data, no read-back
//
//  Native mode takes one pixel per cycle while the job queue is not full;
//  upscale mode sends two response beats per pixel, which holds the intake.
//  A word passes from its accepted pixel through the job queue, the stage 1
//  register and the output register to rsp_ch.
//  A four-entry job queue lets the front take pixels while responses stall.
//  Synchronous reset clears counters, held pixel, queue and output valid.
// ----------------------------------------------------------------------------
module rgb565_to_yuyv422_packer_top (
   input  logic                            clock,
   input  logic                            reset,
   rgbyp_req_if.sink                       req_ch,
   rgbyp_rsp_if.source                     rsp_ch,
   input  logic                            csr_we,
   input  logic [rgbyp_pkg::CsrIndexW-1:0] csr_index,
   input  logic [rgbyp_pkg::CsrDataW-1:0]  csr_data
);
   import rgbyp_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   job_type       push_job, head_job;
   queue_ctl_type qctl;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_UPSCALE:    cfg_in.upscale    = csr_data[0];
            CSR_ROW_PIXELS: cfg_in.row_pixels = csr_data[ColW-1:0];
            CSR_FRAME_ROWS: cfg_in.frame_rows = csr_data[RowW-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.upscale    <= 1'b0;
         cfg_ff.row_pixels <= RowPixelsReset;
         cfg_ff.frame_rows <= FrameRowsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rgbyp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_ch     (req_ch),
      .queue_full (qctl.full),
      .job_push   (qctl.push),
      .job        (push_job)
   );

   rgbyp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (qctl.push),
      .push_job   (push_job),
      .pop        (qctl.pop),
      .full       (qctl.full),
      .head_valid (qctl.head_valid),
      .head_job   (head_job)
   );

   rgbyp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (qctl.head_valid),
      .head_job   (head_job),
      .pop        (qctl.pop),
      .rsp_ch     (rsp_ch)
   );

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      qctl.push |-> !qctl.full)
      else $error("job pushed into a full queue");

   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      qctl.pop |-> qctl.head_valid)
      else $error("job popped from an empty queue");

   a_full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      qctl.full |-> !req_ch.ready)
      else $error("request ready while queue full");

   a_pop_frees_slot: assert property (@(posedge clock) disable iff (reset)
      (qctl.full && qctl.pop) |=> !qctl.full)
      else $error("queue still full after pop without push");

endmodule

// File: tb/tb_rgb565_to_yuyv422_packer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb565_to_yuyv422_packer_top
// Self-checking bench for the RGB565 to YUYV 4:2:2 packer.
// Pixels are pushed on the request channel under random gaps while the
// response channel stalls at random. A scoreboard class mirrors the colour
// conversion, pair packing, 2x duplication and frame addressing, queues the
// words each accepted pixel should cause and checks every response beat
// against them. A directed opener covers the size corners and mode switches,
// then randomised phases re-program the registers between drains.
// ----------------------------------------------------------------------------
import rgbyp_pkg::*;

typedef struct packed {
   logic [ByteW-1:0] luma_first;
   logic [ByteW-1:0] chroma_blue;
   logic [ByteW-1:0] luma_second;
   logic [ByteW-1:0] chroma_red;
   logic [AddrW-1:0] word_address;
   logic             frame_end;
} yuyv_word_type;

class yuyv_scoreboard;
   logic             upscale;
   logic [ColW-1:0]  row_pixels;
   logic [RowW-1:0]  frame_rows;
   logic [ColW-1:0]  column_count;
   logic [RowW-1:0]  row_count;
   logic [ByteW-1:0] held_y;
   logic [ByteW-1:0] held_cb;
   logic [ByteW-1:0] held_cr;
   logic [AddrW-1:0] row_base;
   yuyv_word_type    expected_words[$];
   int               errors;

   function new();
      upscale      = 1'b0;
      row_pixels   = RowPixelsReset;
      frame_rows   = FrameRowsReset;
      column_count = '0;
      row_count    = '0;
      held_y       = '0;
      held_cb      = '0;
      held_cr      = '0;
      row_base     = '0;
      errors       = 0;
   endfunction

   function int pending();
      return expected_words.size();
   endfunction

   function void write_register(csr_index_type idx, logic [CsrDataW-1:0] value);
      case (idx)
         CSR_UPSCALE:    upscale = value[0];
         CSR_ROW_PIXELS: row_pixels = value[ColW-1:0];
         CSR_FRAME_ROWS: frame_rows = value[RowW-1:0];
         default: ;
      endcase
   endfunction

   function int unsigned effective_size(int unsigned v, int unsigned cap);
      if (v == 0)
         return 1;
      if (v > cap)
         return cap;
      return v;
   endfunction

   function yuyv_word_type make_word(logic [ByteW-1:0] y0, logic [ByteW-1:0] cb,
                                     logic [ByteW-1:0] y1, logic [ByteW-1:0] cr,
                                     logic [AddrW-1:0] addr, logic last);
      yuyv_word_type w;
      w.luma_first   = y0;
      w.chroma_blue  = cb;
      w.luma_second  = y1;
      w.chroma_red   = cr;
      w.word_address = addr;
      w.frame_end    = last;
      return w;
   endfunction

   // widen by bit replication, BT.601 limited range, flooring shifts
   function void to_ycbcr(input logic [PixelW-1:0] px, output logic [ByteW-1:0] y,
                          output logic [ByteW-1:0] cb, output logic [ByteW-1:0] cr);
      int r, g, b;
      r  = int'({px[15:11], px[15:13]});
      g  = int'({px[10:5], px[10:9]});
      b  = int'({px[4:0], px[4:2]});
      y  = ByteW'(16 + ((66 * r + 129 * g + 25 * b) >>> 8));
      cb = ByteW'(128 + ((-38 * r - 74 * g + 112 * b) >>> 8));
      cr = ByteW'(128 + ((112 * r - 94 * g - 18 * b) >>> 8));
   endfunction

   function void note_pixel(logic [PixelW-1:0] px);
      int unsigned      rp, fr, stride;
      int               cb_avg, cr_avg;
      logic [ByteW-1:0] y, cb, cr;
      logic [AddrW-1:0] addr;
      bit               row_last, frame_last;
      rp = effective_size(row_pixels, upscale ? MaxOutWidth / 2 : MaxOutWidth);
      fr = effective_size(frame_rows, upscale ? MaxOutHeight / 2 : MaxOutHeight);
      row_last   = (int'(column_count) + 1) >= rp;
      frame_last = row_last && ((int'(row_count) + 1) >= fr);
      to_ycbcr(px, y, cb, cr);
      if (upscale) begin
         addr = row_base + AddrW'(column_count);
         expected_words.push_back(make_word(y, cb, y, cr, addr, 1'b0));
         expected_words.push_back(make_word(y, cb, y, cr, addr + AddrW'(rp), frame_last));
         stride = 2 * rp;
      end else begin
         addr = row_base + AddrW'(column_count >> 1);
         if (!column_count[0]) begin
            if (row_last) begin
               expected_words.push_back(make_word(y, cb, y, cr, addr, frame_last));
            end else begin
               held_y  = y;
               held_cb = cb;
               held_cr = cr;
            end
         end else begin
            cb_avg = (int'(held_cb) + int'(cb)) >> 1;
            cr_avg = (int'(held_cr) + int'(cr)) >> 1;
            expected_words.push_back(make_word(held_y, ByteW'(cb_avg), y,
                                               ByteW'(cr_avg), addr, frame_last));
         end
         stride = (rp + 1) / 2;
      end
      if (row_last) begin
         column_count = '0;
         if (frame_last) begin
            row_count = '0;
            row_base  = '0;
         end else begin
            row_count = row_count + 1'b1;
            row_base  = row_base + AddrW'(stride);
         end
      end else begin
         column_count = column_count + 1'b1;
      end
   endfunction

   function int field_mismatch(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
         return 1;
      end
      return 0;
   endfunction

   function void check_word(yuyv_word_type got);
      yuyv_word_type want;
      if (expected_words.size() == 0) begin
         $display("%0t: unexpected word, expected none actual 0x%0h", $time, got);
         errors++;
         return;
      end
      want = expected_words.pop_front();
      errors += field_mismatch("luma_first", want.luma_first, got.luma_first);
      errors += field_mismatch("chroma_blue", want.chroma_blue, got.chroma_blue);
      errors += field_mismatch("luma_second", want.luma_second, got.luma_second);
      errors += field_mismatch("chroma_red", want.chroma_red, got.chroma_red);
      errors += field_mismatch("word_address", want.word_address, got.word_address);
      errors += field_mismatch("frame_end", want.frame_end, got.frame_end);
   endfunction
endclass

module tb_rgb565_to_yuyv422_packer_top;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CsrIndexW-1:0] csr_index;
   logic [CsrDataW-1:0]  csr_data;

   rgbyp_req_if req_bus ();
   rgbyp_rsp_if rsp_bus ();

   yuyv_scoreboard sb;
   bit             idle_on;
   bit             hold_request;
   int unsigned    pixels_sent;

   rgb565_to_yuyv422_packer_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_pixel(req_bus.pixel);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_word(sb.make_word(rsp_bus.luma_first, rsp_bus.chroma_blue,
                                       rsp_bus.luma_second, rsp_bus.chroma_red,
                                       rsp_bus.word_address, rsp_bus.frame_end));
      end
   end

   // response side: random stalls, or one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_bus.ready <= !(idle_on && $urandom_range(99) < 34);
         end
      end
   end

   initial begin
      #3000000;
      $display("status: fail");
      $finish;
   end

   task automatic write_register(csr_index_type idx, logic [CsrDataW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.write_register(idx, value);
      @(posedge clock);
   endtask

   task automatic send_pixel(logic [PixelW-1:0] px);
      while (idle_on && $urandom_range(99) < 34) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel <= px;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      pixels_sent++;
   endtask

   // wait for every expected word, then let a trailing held pixel settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   initial begin
      logic [PixelW-1:0] px;
      int unsigned       count;
      int unsigned       phase;
      sb            = new();
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.pixel = '0;
      csr_we        = 1'b0;
      csr_index     = CSR_UPSCALE;
      csr_data      = '0;
      idle_on       = 1'b1;
      hold_request  = 1'b0;
      pixels_sent   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // odd native column straight after reset pairs with a zero held pixel
      write_register(CSR_UPSCALE, 1);
      write_register(CSR_ROW_PIXELS, 4);
      write_register(CSR_FRAME_ROWS, 2);
      send_pixel(16'hFFFF);
      drain();
      write_register(CSR_UPSCALE, 0);
      send_pixel(16'h0000);
      send_pixel(16'hF800);
      send_pixel(16'h07E0);
      send_pixel(16'h001F);
      send_pixel(16'h8410);
      drain();

      // odd row width: last pixel paired with itself
      write_register(CSR_ROW_PIXELS, 3);
      write_register(CSR_FRAME_ROWS, 1);
      send_pixel(16'hFFFF);
      send_pixel(16'h0000);
      send_pixel(16'h7BEF);
      drain();

      // zero sizes act as one
      write_register(CSR_ROW_PIXELS, 0);
      write_register(CSR_FRAME_ROWS, 0);
      send_pixel(16'hF81F);
      send_pixel(16'h07FF);
      drain();

      // oversized sizes saturate, then a shrink ends row and frame early
      write_register(CSR_UPSCALE, 1);
      write_register(CSR_ROW_PIXELS, 10'h3FF);
      write_register(CSR_FRAME_ROWS, 10'h1FF);
      send_pixel(16'h1234);
      send_pixel(16'hEDCB);
      drain();
      write_register(CSR_UPSCALE, 0);
      write_register(CSR_ROW_PIXELS, 2);
      write_register(CSR_FRAME_ROWS, 1);
      send_pixel(16'hA5A5);
      drain();
      write_register(CSR_ROW_PIXELS, 10'h3FF);
      write_register(CSR_FRAME_ROWS, 0);
      send_pixel(16'h5A5A);
      send_pixel(16'hFFFF);
      send_pixel(16'h0000);
      drain();
      write_register(CSR_UPSCALE, 1);
      write_register(CSR_ROW_PIXELS, 2);
      write_register(CSR_FRAME_ROWS, 2);
      send_pixel(16'hFFFF);
      send_pixel(16'h0000);
      send_pixel(16'hF800);
      send_pixel(16'h001F);

      phase = 0;
      while (pixels_sent < 950) begin
         drain();
         idle_on = !(phase >= 6 && phase <= 9);
         if (phase % 7 == 3) begin
            write_register(CSR_UPSCALE, CsrDataW'($urandom_range(1)));
            case ($urandom_range(6))
               0: write_register(CSR_ROW_PIXELS, 0);
               1: write_register(CSR_ROW_PIXELS, 1);
               2: write_register(CSR_ROW_PIXELS, 2);
               3: write_register(CSR_ROW_PIXELS, 256);
               4: write_register(CSR_ROW_PIXELS, 512);
               5: write_register(CSR_ROW_PIXELS, 513);
               default: write_register(CSR_ROW_PIXELS, 10'h3FF);
            endcase
            case ($urandom_range(6))
               0: write_register(CSR_FRAME_ROWS, 0);
               1: write_register(CSR_FRAME_ROWS, 1);
               2: write_register(CSR_FRAME_ROWS, 240);
               3: write_register(CSR_FRAME_ROWS, 241);
               4: write_register(CSR_FRAME_ROWS, 480);
               5: write_register(CSR_FRAME_ROWS, 481);
               default: write_register(CSR_FRAME_ROWS, 10'h1FF);
            endcase
         end else begin
            if (phase == 0 || $urandom_range(2) != 0)
               write_register(CSR_UPSCALE, CsrDataW'($urandom_range(1)));
            if (phase == 0 || $urandom_range(2) != 0)
               write_register(CSR_ROW_PIXELS, CsrDataW'($urandom_range(1, 12)));
            if (phase == 0 || $urandom_range(2) != 0)
               write_register(CSR_FRAME_ROWS, CsrDataW'($urandom_range(1, 5)));
         end
         if (phase == 12)
            hold_request = 1'b1;
         count = (phase == 12) ? 60 : $urandom_range(8, 48);
         repeat (count) begin
            case ($urandom_range(11))
               0: px = 16'h0000;
               1: px = 16'hFFFF;
               2: px = {5'h1F, 11'h000} | PixelW'($urandom_range(1));
               3: px = 16'h07E0 ^ PixelW'($urandom_range(3));
               default: px = PixelW'($urandom);
            endcase
            send_pixel(px);
         end
         phase++;
      end

      drain();
      if (sb.pending() != 0)
         $display("%0t: %0d expected words never arrived", $time, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
